// File: src/rseg_pkg.sv
`default_nettype none

package rseg_pkg;

  // Saturation width of the generated value
  localparam int unsigned VALUE_WIDTH = 32;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  localparam logic [31:0] LCG_MUL    = 32'd1664525;
  localparam logic [31:0] LCG_ADD    = 32'd1013904223;
  localparam logic [31:0] SEED_RESET = 32'd1;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [30:0] PIH_Q30    = 31'd1686629713;
  localparam logic [32:0] ONE_Q30    = 33'd1073741824;

  // Job queue between the draw front end and the arithmetic back end
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    REG_SEED = 3'd0,
    REG_ROWS = 3'd1,
    REG_COLS = 3'd2,
    REG_MODE = 3'd3,
    REG_A    = 3'd4,
    REG_B    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_UNIFORM = 2'd0,
    MODE_NORMAL  = 2'd1,
    MODE_CONST   = 2'd2,
    MODE_NONE    = 2'd3
  } value_mode_t;

  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] rows;
    logic [31:0] cols;
    logic [1:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
  } rseg_cfg_t;

  typedef struct packed {
    logic [31:0] dr;
    logic [31:0] dc;
    logic [31:0] d1;
    logic [31:0] d2;
  } rseg_job_t;

  typedef enum logic [1:0] {
    F_IDLE = 2'd0,
    F_DRAW = 2'd1,
    F_PUSH = 2'd2
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_ROW_GO, B_ROW_WAIT, B_COL_GO, B_COL_WAIT, B_VAL,
    B_U_LO, B_U_HI, B_U_SUM,
    B_N_NORM, B_N_SQ, B_N_FIX, B_N_LOG, B_N_W, B_N_SQRT,
    B_N_T, B_N_T2, B_N_H0, B_N_HMUL, B_N_HDIV, B_N_HWAIT, B_N_HFIX,
    B_N_RC, B_N_BZ, B_N_SUM, B_OUT
  } back_state_t;

  // Taylor divisors of the cosine series, innermost term first
  function automatic logic [7:0] cos_div(input logic [2:0] k);
    logic [7:0] d;
    case (k)
      3'd0:    d = 8'd132;
      3'd1:    d = 8'd90;
      3'd2:    d = 8'd56;
      3'd3:    d = 8'd30;
      3'd4:    d = 8'd12;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for each series divisor
  function automatic logic [31:0] cos_recip(input logic [2:0] k);
    logic [31:0] r;
    case (k)
      3'd0:    r = 32'd32537631;
      3'd1:    r = 32'd47721858;
      3'd2:    r = 32'd76695844;
      3'd3:    r = 32'd143165576;
      3'd4:    r = 32'd357913941;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] saturate(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[31:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/rseg_front.sv
`default_nettype none

module rseg_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rseg_pkg::rseg_cfg_t cfg,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic                restart,
  output logic                     push,
  output rseg_pkg::rseg_job_t      job,
  input  wire logic                full
);

  rseg_pkg::front_state_t state, state_next;
  logic [31:0] lcg;
  logic [31:0] lcg_step;
  logic [1:0]  cnt;
  logic [1:0]  last;
  logic [31:0] draws [4];

  assign lcg_step = lcg * rseg_pkg::LCG_MUL + rseg_pkg::LCG_ADD;

  always_comb begin
    case (rseg_pkg::value_mode_t'(cfg.mode))
      rseg_pkg::MODE_UNIFORM: last = 2'd2;
      rseg_pkg::MODE_NORMAL:  last = 2'd3;
      default:                last = 2'd1;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      rseg_pkg::F_IDLE: if (s_tvalid) state_next = rseg_pkg::F_DRAW;
      rseg_pkg::F_DRAW: if (cnt == last) state_next = rseg_pkg::F_PUSH;
      rseg_pkg::F_PUSH: if (!full) state_next = rseg_pkg::F_IDLE;
      default:          state_next = rseg_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == rseg_pkg::F_IDLE);
    push     = (state == rseg_pkg::F_PUSH) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rseg_pkg::F_IDLE;
      lcg   <= rseg_pkg::SEED_RESET;
      cnt   <= 2'd0;
    end else begin
      state <= state_next;
      if (state == rseg_pkg::F_IDLE) begin
        cnt <= 2'd0;
        if (s_tvalid && restart) lcg <= cfg.seed;
      end
      if (state == rseg_pkg::F_DRAW) begin
        lcg        <= lcg_step;
        draws[cnt] <= lcg_step;
        cnt        <= cnt + 2'd1;
      end
    end
  end

  assign job.dr = draws[0];
  assign job.dc = draws[1];
  assign job.d1 = draws[2];
  assign job.d2 = draws[3];

endmodule

`default_nettype wire

// File: src/rseg_queue.sv
`default_nettype none

module rseg_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rseg_pkg::rseg_job_t wr_job,
  output logic                     full,
  input  wire logic                pop,
  output rseg_pkg::rseg_job_t      rd_job,
  output logic                     empty
);

  rseg_pkg::rseg_job_t slots [rseg_pkg::QDEPTH];
  logic [rseg_pkg::QAW-1:0] wptr, rptr;
  logic [rseg_pkg::QAW:0]   count;

  assign full   = (count == (rseg_pkg::QAW+1)'(rseg_pkg::QDEPTH));
  assign empty  = (count == '0);
  assign rd_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= wr_job;
        wptr        <= wptr + 1'b1;
      end
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/rseg_div.sv
`default_nettype none

module rseg_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quo,
  output logic [31:0]      rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dsr;
  logic [32:0] sh;
  logic [32:0] diff;

  // one quotient bit a cycle, restoring
  assign sh   = {rem, quo[31]};
  assign diff = sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        quo  <= dividend;
        rem  <= 32'd0;
        dsr  <= divisor;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) busy <= 1'b0;
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= sh[31:0];
          quo <= {quo[30:0], 1'b0};
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/rseg_back.sv
`default_nettype none

module rseg_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rseg_pkg::rseg_cfg_t cfg,
  input  wire logic                empty,
  input  wire rseg_pkg::rseg_job_t rd_job,
  output logic                     pop,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [95:0]              m_tdata
);

  rseg_pkg::back_state_t state, state_next;
  rseg_pkg::rseg_job_t   job;

  logic [31:0] row_w, col_w, val_w;

  // shared multiplier, registered
  logic signed [33:0] mul_x;
  logic signed [32:0] mul_y;
  logic signed [66:0] prod;
  logic signed [49:0] plo;

  // shared divider
  logic        div_start, div_done;
  logic [31:0] div_a, div_b, div_q, div_r;

  // normal path
  logic [31:0] m;
  logic [4:0]  zc;
  logic [4:0]  it;
  logic [23:0] frac;
  logic [32:0] sq;
  logic [29:0] lval;
  logic [39:0] rad;
  logic [21:0] srem;
  logic [19:0] root;
  logic [23:0] cur;
  logic [23:0] trial;
  logic [30:0] xx;
  logic [31:0] t2;
  logic signed [32:0] h;
  logic signed [32:0] cval;
  logic        hneg;
  logic [2:0]  ck;
  logic [66:0] pabs;
  logic [1:0]  quad;
  // series term: reciprocal estimate, then one correction step
  logic [31:0] hnum, hest, hrem, hq;

  logic signed [32:0] a_s, b_s, diff;
  logic signed [50:0] usum;
  logic signed [63:0] uval, nval;
  logic signed [55:0] bzs;
  logic signed [23:0] zval;

  assign a_s   = {cfg.a[31], cfg.a};
  assign b_s   = {cfg.b[31], cfg.b};
  assign diff  = b_s - a_s;
  assign quad  = job.d2[31:30];
  assign sq    = prod[63:31];
  assign lval  = {6'(zc) + 6'd1, 24'd0} - {6'd0, frac};
  assign cur   = {srem, rad[39:38]};
  assign trial = {2'b00, root, 2'b01};
  assign xx    = quad[0] ? (31'h4000_0000 - {1'b0, job.d2[29:0]}) : {1'b0, job.d2[29:0]};
  assign cval  = (quad == 2'd1 || quad == 2'd2) ? -h : h;
  assign pabs  = prod[66] ? 67'(-prod) : 67'(prod);
  assign zval  = $signed(prod[53:30]);
  assign bzs   = $signed(prod[55:0]);
  assign usum  = 51'($signed(prod[49:0])) + 51'(plo >>> 16);
  assign uval  = 64'(a_s) + 64'(usum >>> 16);
  assign nval  = 64'(a_s) + 64'(bzs >>> 16);
  assign hq    = (hrem >= {24'd0, rseg_pkg::cos_div(ck)}) ? hest + 32'd1 : hest;

  rseg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  always_comb begin
    state_next = state;
    case (state)
      rseg_pkg::B_IDLE:     if (!empty) state_next = rseg_pkg::B_ROW_GO;
      rseg_pkg::B_ROW_GO:   state_next = rseg_pkg::B_ROW_WAIT;
      rseg_pkg::B_ROW_WAIT: if (div_done) state_next = rseg_pkg::B_COL_GO;
      rseg_pkg::B_COL_GO:   state_next = rseg_pkg::B_COL_WAIT;
      rseg_pkg::B_COL_WAIT: if (div_done) state_next = rseg_pkg::B_VAL;
      rseg_pkg::B_VAL: begin
        case (rseg_pkg::value_mode_t'(cfg.mode))
          rseg_pkg::MODE_UNIFORM: state_next = rseg_pkg::B_U_LO;
          rseg_pkg::MODE_NORMAL:  state_next = rseg_pkg::B_N_NORM;
          default:                state_next = rseg_pkg::B_OUT;
        endcase
      end
      rseg_pkg::B_U_LO:     state_next = rseg_pkg::B_U_HI;
      rseg_pkg::B_U_HI:     state_next = rseg_pkg::B_U_SUM;
      rseg_pkg::B_U_SUM:    state_next = rseg_pkg::B_OUT;
      rseg_pkg::B_N_NORM:   if (m[31]) state_next = rseg_pkg::B_N_SQ;
      rseg_pkg::B_N_SQ:     state_next = rseg_pkg::B_N_FIX;
      rseg_pkg::B_N_FIX:    state_next = (it == 5'd23) ? rseg_pkg::B_N_LOG : rseg_pkg::B_N_SQ;
      rseg_pkg::B_N_LOG:    state_next = rseg_pkg::B_N_W;
      rseg_pkg::B_N_W:      state_next = rseg_pkg::B_N_SQRT;
      rseg_pkg::B_N_SQRT:   if (it == 5'd19) state_next = rseg_pkg::B_N_T;
      rseg_pkg::B_N_T:      state_next = rseg_pkg::B_N_T2;
      rseg_pkg::B_N_T2:     state_next = rseg_pkg::B_N_H0;
      rseg_pkg::B_N_H0:     state_next = rseg_pkg::B_N_HMUL;
      rseg_pkg::B_N_HMUL:   state_next = rseg_pkg::B_N_HDIV;
      rseg_pkg::B_N_HDIV:   state_next = rseg_pkg::B_N_HWAIT;
      rseg_pkg::B_N_HWAIT:  state_next = rseg_pkg::B_N_HFIX;
      rseg_pkg::B_N_HFIX: begin
        state_next = (ck == 3'd5) ? rseg_pkg::B_N_RC : rseg_pkg::B_N_HMUL;
      end
      rseg_pkg::B_N_RC:     state_next = rseg_pkg::B_N_BZ;
      rseg_pkg::B_N_BZ:     state_next = rseg_pkg::B_N_SUM;
      rseg_pkg::B_N_SUM:    state_next = rseg_pkg::B_OUT;
      rseg_pkg::B_OUT:      if (!m_tvalid || m_tready) state_next = rseg_pkg::B_IDLE;
      default:              state_next = rseg_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == rseg_pkg::B_IDLE) && !empty;
    div_start = 1'b0;
    div_a     = job.dr;
    div_b     = cfg.rows;
    mul_x     = '0;
    mul_y     = '0;
    case (state)
      rseg_pkg::B_ROW_GO: div_start = 1'b1;
      rseg_pkg::B_COL_GO: begin
        div_start = 1'b1;
        div_a     = job.dc;
        div_b     = cfg.cols;
      end
      rseg_pkg::B_N_HDIV: begin
        mul_x = $signed({2'b00, pabs[61:30]});
        mul_y = $signed({1'b0, rseg_pkg::cos_recip(ck)});
      end
      rseg_pkg::B_U_LO: begin
        mul_x = 34'(diff);
        mul_y = $signed({17'd0, job.d1[15:0]});
      end
      rseg_pkg::B_U_HI: begin
        mul_x = 34'(diff);
        mul_y = $signed({17'd0, job.d1[31:16]});
      end
      rseg_pkg::B_N_SQ: begin
        mul_x = $signed({2'b00, m});
        mul_y = $signed({1'b0, m});
      end
      rseg_pkg::B_N_LOG: begin
        mul_x = $signed({4'd0, lval});
        mul_y = $signed({1'b0, rseg_pkg::LN2_Q32});
      end
      rseg_pkg::B_N_T: begin
        mul_x = $signed({3'd0, xx});
        mul_y = $signed({2'd0, rseg_pkg::PIH_Q30});
      end
      rseg_pkg::B_N_T2: begin
        mul_x = $signed({3'd0, prod[60:30]});
        mul_y = $signed({2'd0, prod[60:30]});
      end
      rseg_pkg::B_N_HMUL: begin
        mul_x = $signed({2'b00, t2});
        mul_y = h;
      end
      rseg_pkg::B_N_RC: begin
        mul_x = $signed({14'd0, root});
        mul_y = cval;
      end
      rseg_pkg::B_N_BZ: begin
        mul_x = 34'(b_s);
        mul_y = 33'(zval);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 67'(mul_x * mul_y);
    if (rst) begin
      state    <= rseg_pkg::B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rseg_pkg::B_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {val_w, col_w, row_w};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        rseg_pkg::B_IDLE: if (!empty) job <= rd_job;
        rseg_pkg::B_ROW_WAIT: begin
          if (div_done) row_w <= (cfg.rows == 32'd0) ? 32'd0 : div_r;
        end
        rseg_pkg::B_COL_WAIT: begin
          if (div_done) col_w <= (cfg.cols == 32'd0) ? 32'd0 : div_r;
        end
        rseg_pkg::B_VAL: begin
          m  <= (job.d1 == 32'd0) ? 32'd1 : job.d1;
          zc <= 5'd0;
          if (cfg.mode == rseg_pkg::MODE_CONST) val_w <= rseg_pkg::saturate(64'(a_s));
          else val_w <= 32'd0;
        end
        rseg_pkg::B_U_HI: plo <= $signed(prod[49:0]);
        rseg_pkg::B_U_SUM: val_w <= rseg_pkg::saturate(uval);
        rseg_pkg::B_N_NORM: begin
          it   <= 5'd0;
          frac <= 24'd0;
          if (!m[31]) begin
            m  <= {m[30:0], 1'b0};
            zc <= zc + 5'd1;
          end
        end
        rseg_pkg::B_N_FIX: begin
          it   <= it + 5'd1;
          frac <= {frac[22:0], sq[32]};
          m    <= sq[32] ? sq[32:1] : sq[31:0];
        end
        rseg_pkg::B_N_W: begin
          rad  <= {1'b0, prod[61:31], 8'd0};
          srem <= 22'd0;
          root <= 20'd0;
          it   <= 5'd0;
        end
        rseg_pkg::B_N_SQRT: begin
          it  <= it + 5'd1;
          rad <= {rad[37:0], 2'b00};
          if (cur >= trial) begin
            srem <= 22'(cur - trial);
            root <= {root[18:0], 1'b1};
          end else begin
            srem <= cur[21:0];
            root <= {root[18:0], 1'b0};
          end
        end
        rseg_pkg::B_N_H0: begin
          t2 <= prod[61:30];
          h  <= rseg_pkg::ONE_Q30;
          ck <= 3'd0;
        end
        rseg_pkg::B_N_HDIV: begin
          hneg <= prod[66];
          hnum <= pabs[61:30];
        end
        // estimate is the true quotient or one below it
        rseg_pkg::B_N_HWAIT: begin
          hest <= prod[63:32];
          hrem <= hnum - 32'(prod[63:32] * rseg_pkg::cos_div(ck));
        end
        rseg_pkg::B_N_HFIX: begin
          ck <= ck + 3'd1;
          h  <= hneg ? $signed(rseg_pkg::ONE_Q30 + {1'b0, hq})
                     : $signed(rseg_pkg::ONE_Q30 - {1'b0, hq});
        end
        rseg_pkg::B_N_SUM: val_w <= rseg_pkg::saturate(nval);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/random_sparse_entry_generator.sv
`default_nettype none

// Channel   Direction  Signals                         Contents
// s_axis    in         s_tvalid s_tready s_tdata[7:0]  [0] restart, rest zero
// m_axis    out        m_tvalid m_tready m_tdata[95:0] row, column, value (Q16.16)
// config    in         cfg_we cfg_index cfg_data       write-only register file
//
// The front end takes a transaction, then steps the generator once for each
// draw it needs and hands the job to a two-entry queue, waiting while it is full.
// The back end runs two divisions for the indices, then a short multiply
// sequence for uniform values (constant and zero values need none); a normal
// value adds the log (normalise, then repeated squaring), a square root and
// six series terms.
// The back end sets the rate. Reset is synchronous and clears control
// state only. Either side may stall: the queue and the output register hold.
module random_sparse_entry_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // [31:0] row_index, [63:32] col_index,
                                      // [95:64] entry_value
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  rseg_pkg::rseg_cfg_t cfg;
  rseg_pkg::rseg_job_t wr_job, rd_job;
  logic push, full, pop, empty;

  // Register file; a new seed takes effect only at the next restart
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed <= rseg_pkg::SEED_RESET;
      cfg.rows <= 32'd1;
      cfg.cols <= 32'd1;
      cfg.mode <= rseg_pkg::MODE_UNIFORM;
      cfg.a    <= 32'd0;
      cfg.b    <= 32'd65536;
    end else if (cfg_we) begin
      case (rseg_pkg::cfg_reg_t'(cfg_index))
        rseg_pkg::REG_SEED: cfg.seed <= cfg_data;
        rseg_pkg::REG_ROWS: cfg.rows <= cfg_data;
        rseg_pkg::REG_COLS: cfg.cols <= cfg_data;
        rseg_pkg::REG_MODE: cfg.mode <= cfg_data[1:0];
        rseg_pkg::REG_A:    cfg.a    <= cfg_data;
        rseg_pkg::REG_B:    cfg.b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: take the transaction and make all draws for it
  rseg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .restart  (s_tdata[0]),
    .push     (push),
    .job      (wr_job),
    .full     (full)
  );

  // Hold finished draws until the back end is free
  rseg_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .full   (full),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (empty)
  );

  // Back: reduce the indices and shape the value
  rseg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .rd_job   (rd_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// File: src/rseg_checker.sv
`default_nettype none

module rseg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata
);

  logic [3:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 4'd0;
    end else begin
      pend <= pend + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend != 4'd0)
    else $error("result without a pending transaction");

endmodule

bind random_sparse_entry_generator rseg_checker u_rseg_checker (.*);

`default_nettype wire
